// ----- src/limit_order_book_matcher_macros.svh -----
// Assertion helpers for the order book matcher checker
`ifndef LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`define LOB_ASSERT_IMPL(label, clk_i, rst_n, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lob check failed");
`define LOB_ASSERT_NEXT(label, clk_i, rst_n, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lob check failed");
`endif

// ----- src/lobm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;
	localparam int ORDER_SLOTS = 64;
	localparam int SLOT_W = $clog2(ORDER_SLOTS);
	localparam int QDEPTH = 2;

	localparam logic [1:0] FUNC_SUBMIT = 2'd0;
	localparam logic [1:0] FUNC_REST   = 2'd1;
	localparam logic [1:0] FUNC_CANCEL = 2'd2;
	localparam logic [1:0] FUNC_MODIFY = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_FND  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_ZERO_QTY = 2'd3;

	// classified request word passed from front to back
	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] req_id;
		logic        side;
		logic [31:0] price;
		logic [31:0] quantity;
		logic        zero_qty;
	} req_t;
endpackage
`default_nettype wire

// ----- src/lobm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Accepts requests, tags zero quantity, and queues them for the engine.
module lobm_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  [1:0]          func,
	input  wire  [31:0]         req_id,
	input  wire                 side,
	input  wire  [31:0]         price,
	input  wire  [31:0]         quantity,
	output logic                q_valid,
	input  wire                 q_pop,
	output lobm_pkg::req_t      q_word
);
	localparam int PW = $clog2(lobm_pkg::QDEPTH);
	lobm_pkg::req_t mem_q [lobm_pkg::QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic rdy_q;
	logic push, pop;

	// held off during reset and until the first edge after it
	assign in_stall = !rdy_q || (cnt_q == (PW+1)'(lobm_pkg::QDEPTH));
	assign push = in_valid && !in_stall;
	assign pop = q_pop && q_valid;
	assign q_valid = (cnt_q != '0);
	assign q_word = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{func: func, req_id: req_id, side: side, price: price,
				quantity: quantity, zero_qty: (quantity == 32'd0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			rdy_q <= 1'b0;
		end else begin
			rdy_q <= 1'b1;
			if (push) wp_q <= wp_q + PW'(1);
			if (pop) rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

// ----- src/lobm_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Executes one request at a time. Slot store is scanned one slot per cycle.
// Fills are parked in a buffer and sent once the final best bid/ask is known.
module lobm_engine (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             q_valid,
	output logic            q_pop,
	input  lobm_pkg::req_t  q_word,
	output logic            out_valid,
	input  wire             out_stall,
	output logic            trade_valid,
	output logic [31:0]     taker_id,
	output logic [31:0]     maker_id,
	output logic [31:0]     trade_price,
	output logic [31:0]     trade_quantity,
	output logic [1:0]      status,
	output logic [31:0]     bid_top,
	output logic [31:0]     ask_top,
	output logic [31:0]     spread,
	output logic            last
);
	localparam int N = lobm_pkg::ORDER_SLOTS;
	localparam int SW = lobm_pkg::SLOT_W;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_DECIDE = 7'b0000100,
		S_FILL   = 7'b0001000,
		S_PLACE  = 7'b0010000,
		S_EMIT   = 7'b0100000,
		S_NEXT   = 7'b1000000
	} st_t;
	st_t st_q;

	typedef struct packed {
		logic [31:0] mid;
		logic [31:0] px;
		logic [31:0] qt;
	} fill_t;

	// valid bits in flops; payload in memories read one slot per cycle
	logic [N-1:0] vld_q;
	logic [31:0] id_m [N];
	logic        sd_m [N];
	logic [31:0] px_m [N];
	logic [31:0] qt_m [N];
	logic [31:0] ar_m [N];
	fill_t       fb_m [N];
	logic [31:0] arr_q;

	lobm_pkg::req_t r_q;
	logic [SW:0]   idx_q;
	logic [SW-1:0] ri;
	logic [31:0]   rd_id_q, rd_px_q, rd_qt_q, rd_ar_q;
	logic          rd_sd_q;
	fill_t         fb_rd_q;
	logic          rd_ok_q;          // registered read data valid
	logic [SW-1:0] rd_idx_q;

	logic          hit_q;
	logic [SW-1:0] hit_i_q;
	logic [31:0]   hit_px_q, hit_qt_q, hit_age_q, hit_id_q;
	logic [31:0]   qty_q;
	logic [1:0]    stat_q;
	logic          hb_q, ha_q;
	logic [31:0]   bid_q, ask_q;
	logic          mode_best_q;
	logic [SW:0]   nfill_q;
	logic [SW-1:0] emit_q;

	logic [31:0]   age, fill, sp;
	logic          cand, better, rv;
	logic          free_any;
	logic [SW-1:0] free_i;
	logic          ld, last_word, mod_move;

	assign ri = idx_q[SW-1:0];

	// read data registered
	always_ff @(posedge clk) begin
		rd_id_q <= id_m[ri];
		rd_px_q <= px_m[ri];
		rd_qt_q <= qt_m[ri];
		rd_ar_q <= ar_m[ri];
		rd_sd_q <= sd_m[ri];
		fb_rd_q <= fb_m[emit_q];
	end

	assign rv = rd_ok_q && vld_q[rd_idx_q];
	assign age = arr_q - rd_ar_q;
	always_comb begin
		cand = 1'b0;
		better = 1'b0;
		if (r_q.func == lobm_pkg::FUNC_SUBMIT) begin
			cand = rv && (rd_sd_q != r_q.side) &&
				(r_q.side ? (rd_px_q >= r_q.price) : (rd_px_q <= r_q.price));
			if (!hit_q) better = 1'b1;
			else if (rd_px_q != hit_px_q)
				better = r_q.side ? (rd_px_q > hit_px_q) : (rd_px_q < hit_px_q);
			else better = age > hit_age_q;
		end else begin
			cand = rv && (rd_id_q == r_q.req_id);
			better = !hit_q;
		end
	end

	// lowest free slot
	always_comb begin
		free_i = '0;
		for (int i = N-1; i >= 0; i--)
			if (!vld_q[i]) free_i = SW'(i);
	end
	assign free_any = !(&vld_q);

	assign fill = (qty_q < hit_qt_q) ? qty_q : hit_qt_q;
	assign sp = (bid_q != '0 && ask_q != '0 && ask_q > bid_q) ? ask_q - bid_q : '0;
	assign mod_move = !(r_q.price == hit_px_q && r_q.quantity <= hit_qt_q);
	assign ld = (st_q == S_EMIT) && (!out_valid || !out_stall);
	assign last_word = (nfill_q == '0) || (({1'b0, emit_q} + (SW+1)'(1)) == nfill_q);
	assign q_pop = (st_q == S_IDLE) && q_valid;

	always_ff @(posedge clk) begin
		if (st_q == S_FILL) begin
			qt_m[hit_i_q] <= hit_qt_q - fill;
			fb_m[nfill_q[SW-1:0]] <= '{mid: hit_id_q, px: hit_px_q, qt: fill};
		end else if (st_q == S_PLACE && free_any) begin
			id_m[free_i] <= r_q.req_id;
			sd_m[free_i] <= r_q.side;
			px_m[free_i] <= r_q.price;
			qt_m[free_i] <= qty_q;
			ar_m[free_i] <= arr_q;
		end else if (st_q == S_DECIDE && r_q.func == lobm_pkg::FUNC_MODIFY && hit_q
				&& !r_q.zero_qty) begin
			qt_m[hit_i_q] <= r_q.quantity;
			if (mod_move) begin
				px_m[hit_i_q] <= r_q.price;
				ar_m[hit_i_q] <= arr_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			vld_q <= '0;
			arr_q <= '0;
			idx_q <= '0;
			rd_ok_q <= 1'b0;
			rd_idx_q <= '0;
			r_q <= '0;
			qty_q <= '0;
			stat_q <= lobm_pkg::ST_OK;
			hit_q <= 1'b0;
			hit_i_q <= '0;
			hit_px_q <= '0;
			hit_qt_q <= '0;
			hit_age_q <= '0;
			hit_id_q <= '0;
			hb_q <= 1'b0;
			ha_q <= 1'b0;
			bid_q <= '0;
			ask_q <= '0;
			mode_best_q <= 1'b0;
			nfill_q <= '0;
			emit_q <= '0;
			out_valid <= 1'b0;
			trade_valid <= 1'b0;
			taker_id <= '0;
			maker_id <= '0;
			trade_price <= '0;
			trade_quantity <= '0;
			status <= lobm_pkg::ST_OK;
			bid_top <= '0;
			ask_top <= '0;
			spread <= '0;
			last <= 1'b0;
		end else begin
			rd_ok_q <= (st_q == S_SCAN) && (idx_q < (SW+1)'(N));
			rd_idx_q <= idx_q[SW-1:0];
			if (ld) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (ld) begin
				if (nfill_q == '0) begin
					trade_valid <= 1'b0;
					taker_id <= '0;
					maker_id <= '0;
					trade_price <= '0;
					trade_quantity <= '0;
				end else begin
					trade_valid <= 1'b1;
					taker_id <= r_q.req_id;
					maker_id <= fb_rd_q.mid;
					trade_price <= fb_rd_q.px;
					trade_quantity <= fb_rd_q.qt;
				end
				status <= stat_q;
				bid_top <= bid_q;
				ask_top <= ask_q;
				spread <= sp;
				last <= last_word;
			end
			case (st_q)
				S_IDLE: if (q_valid) begin
					r_q <= q_word;
					qty_q <= q_word.quantity;
					nfill_q <= '0;
					emit_q <= '0;
					idx_q <= '0;
					hit_q <= 1'b0;
					hb_q <= 1'b0;
					ha_q <= 1'b0;
					bid_q <= '0;
					ask_q <= '0;
					if ((q_word.func == lobm_pkg::FUNC_SUBMIT ||
						q_word.func == lobm_pkg::FUNC_REST) && q_word.zero_qty) begin
						stat_q <= lobm_pkg::ST_ZERO_QTY;
						mode_best_q <= 1'b1;
						st_q <= S_SCAN;
					end else if (q_word.func == lobm_pkg::FUNC_REST) begin
						stat_q <= lobm_pkg::ST_OK;
						mode_best_q <= 1'b0;
						st_q <= S_PLACE;
					end else begin
						stat_q <= lobm_pkg::ST_OK;
						mode_best_q <= 1'b0;
						st_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q < (SW+1)'(N)) idx_q <= idx_q + (SW+1)'(1);
					if (rd_ok_q) begin
						if (mode_best_q) begin
							if (rv) begin
								if (!rd_sd_q) begin
									if (!hb_q || rd_px_q > bid_q) bid_q <= rd_px_q;
									hb_q <= 1'b1;
								end else begin
									if (!ha_q || rd_px_q < ask_q) ask_q <= rd_px_q;
									ha_q <= 1'b1;
								end
							end
						end else if (cand && better) begin
							hit_q <= 1'b1;
							hit_i_q <= rd_idx_q;
							hit_px_q <= rd_px_q;
							hit_qt_q <= rd_qt_q;
							hit_age_q <= age;
							hit_id_q <= rd_id_q;
						end
					end
					// last slot is evaluated on this edge
					if (idx_q == (SW+1)'(N))
						st_q <= mode_best_q ? S_EMIT : S_DECIDE;
				end
				S_DECIDE: begin
					if (r_q.func == lobm_pkg::FUNC_SUBMIT) begin
						if (hit_q) st_q <= S_FILL;
						else st_q <= S_PLACE;
					end else begin
						if (!hit_q) stat_q <= lobm_pkg::ST_NOT_FND;
						else if (r_q.func == lobm_pkg::FUNC_CANCEL || r_q.zero_qty)
							vld_q[hit_i_q] <= 1'b0;
						else if (mod_move)
							arr_q <= arr_q + 32'd1;
						mode_best_q <= 1'b1;
						idx_q <= '0;
						st_q <= S_SCAN;
					end
				end
				S_FILL: begin
					nfill_q <= nfill_q + (SW+1)'(1);
					qty_q <= qty_q - fill;
					if (hit_qt_q == fill) vld_q[hit_i_q] <= 1'b0;
					hit_q <= 1'b0;
					idx_q <= '0;
					if (qty_q == fill) begin
						mode_best_q <= 1'b1;
						st_q <= S_SCAN;
					end else if (nfill_q == (SW+1)'(N-1)) begin
						st_q <= S_PLACE;
					end else begin
						st_q <= S_SCAN;
					end
				end
				S_PLACE: begin
					if (free_any) begin
						vld_q[free_i] <= 1'b1;
						arr_q <= arr_q + 32'd1;
					end else begin
						stat_q <= lobm_pkg::ST_FULL;
					end
					mode_best_q <= 1'b1;
					idx_q <= '0;
					st_q <= S_SCAN;
				end
				S_EMIT: if (ld) begin
					if (last_word) begin
						st_q <= S_IDLE;
					end else begin
						emit_q <= emit_q + SW'(1);
						st_q <= S_NEXT;
					end
				end
				// lets the registered fill buffer read catch up
				S_NEXT: st_q <= S_EMIT;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- src/limit_order_book_matcher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Price-time priority limit order book.
// Input channel: in_valid/in_stall carrying func, req_id, side, price, quantity.
// Output channel: out_valid/out_stall carrying one word per fill, or one word when
// nothing fills; last marks the final word of a request. Status, best bid, best ask
// and spread are the values after the whole request and repeat on every word of it.
// A two-entry request queue decouples the input from the matching engine, which
// works on one request at a time over a 64-slot store. A rest-only add places the
// order and then sweeps the store for best bid and ask; a zero-quantity submit or
// add does only that sweep. Cancel, modify and submit first sweep for a match, and
// a submit sweeps again after each fill that leaves the taker open.
// The next request is popped the cycle after the last word is loaded.
// Reset empties the book and the queue and clears the arrival counter; in_stall is
// high during reset and drops on the first edge after it.
// A stalled output holds its word; the engine waits and the queue then fills
// and raises in_stall.
module limit_order_book_matcher (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  func,
	input  wire  [31:0] req_id,
	input  wire         side,
	input  wire  [31:0] price,
	input  wire  [31:0] quantity,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        trade_valid,
	output logic [31:0] taker_id,
	output logic [31:0] maker_id,
	output logic [31:0] trade_price,
	output logic [31:0] trade_quantity,
	output logic [1:0]  status,
	output logic [31:0] bid_top,
	output logic [31:0] ask_top,
	output logic [31:0] spread,
	output logic        last
);
	logic q_valid, q_pop;
	lobm_pkg::req_t q_word;

	lobm_front u_front (.clk, .arst_n, .in_valid, .in_stall, .func, .req_id, .side,
		.price, .quantity, .q_valid, .q_pop, .q_word);

	lobm_engine u_engine (.clk, .arst_n, .q_valid, .q_pop, .q_word, .out_valid,
		.out_stall, .trade_valid, .taker_id, .maker_id, .trade_price, .trade_quantity,
		.status, .bid_top, .ask_top, .spread, .last);
endmodule
`default_nettype wire

// ----- src/lobm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "limit_order_book_matcher_macros.svh"
module lobm_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_stall,
	input wire        trade_valid,
	input wire [31:0] trade_quantity,
	input wire [31:0] spread,
	input wire [31:0] bid_top,
	input wire [31:0] ask_top,
	input wire        last
);
	`LOB_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, $stable(trade_quantity) && $stable(last))
	`LOB_ASSERT_IMPL(a_fill_nz, clk, arst_n, out_valid && trade_valid, trade_quantity != 32'd0)
	`LOB_ASSERT_IMPL(a_spread, clk, arst_n, out_valid && last && spread != 32'd0, ask_top > bid_top)
	`LOB_ASSERT_NEXT(a_stay, clk, arst_n, out_valid && out_stall, out_valid)
endmodule
bind limit_order_book_matcher lobm_checker u_chk (.clk, .arst_n, .out_valid, .out_stall,
	.trade_valid, .trade_quantity, .spread, .bid_top, .ask_top, .last);
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
module tb;
	localparam int SLOTS = lobm_pkg::ORDER_SLOTS;
	localparam int CYCLE_LIMIT = 10000000;
	localparam int HOLD_CYCLES = 4000;

	typedef struct {
		logic [1:0]  func;
		logic [31:0] id;
		logic        side;
		logic [31:0] price;
		logic [31:0] qty;
		bit          drain;
	} order_req_t;

	typedef struct {
		logic        trade_valid;
		logic [31:0] taker_id;
		logic [31:0] maker_id;
		logic [31:0] trade_price;
		logic [31:0] trade_quantity;
		logic [1:0]  status;
		logic [31:0] bid_top;
		logic [31:0] ask_top;
		logic [31:0] spread;
		logic        last;
	} book_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = lobm_pkg::FUNC_SUBMIT;
	logic [31:0] req_id = '0;
	logic        side = 1'b0;
	logic [31:0] price = '0;
	logic [31:0] quantity = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        trade_valid;
	logic [31:0] taker_id, maker_id, trade_price, trade_quantity;
	logic [1:0]  status;
	logic [31:0] bid_top, ask_top, spread;
	logic        last;

	limit_order_book_matcher dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow book
	bit          bk_valid [SLOTS];
	logic [31:0] bk_id    [SLOTS];
	logic        bk_side  [SLOTS];
	logic [31:0] bk_price [SLOTS];
	logic [31:0] bk_qty   [SLOTS];
	logic [31:0] bk_stamp [SLOTS];
	logic [31:0] arrival_ctr = '0;

	order_req_t pending_orders[$];
	book_word_t expected_words[$];
	int errors = 0;
	int accepted = 0;
	int cycles = 0;
	bit in_taken = 1'b0;

	function automatic void queue_order(order_req_t r);
		pending_orders.insert(pending_orders.size(), r);
	endfunction

	function automatic int best_maker(logic tside, logic [31:0] lim);
		int best;
		best = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!bk_valid[i] || bk_side[i] == tside)
				continue;
			if (tside == 1'b0 ? bk_price[i] > lim : bk_price[i] < lim)
				continue;
			if (best < 0)
				best = i;
			else if (bk_price[i] != bk_price[best]) begin
				if (tside == 1'b0 ? bk_price[i] < bk_price[best] : bk_price[i] > bk_price[best])
					best = i;
			end else if (32'(arrival_ctr - bk_stamp[i]) > 32'(arrival_ctr - bk_stamp[best]))
				best = i;
		end
		return best;
	endfunction

	function automatic bit book_place(order_req_t r, logic [31:0] q);
		for (int i = 0; i < SLOTS; i++) begin
			if (!bk_valid[i]) begin
				bk_valid[i] = 1'b1;
				bk_id[i] = r.id;
				bk_side[i] = r.side;
				bk_price[i] = r.price;
				bk_qty[i] = q;
				bk_stamp[i] = arrival_ctr;
				arrival_ctr = arrival_ctr + 1;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic apply_order(order_req_t r);
		logic [31:0] mk_id [SLOTS];
		logic [31:0] mk_px [SLOTS];
		logic [31:0] mk_q  [SLOTS];
		logic [31:0] q, fill, bid, ask, spr;
		logic [1:0]  st;
		bit          have_bid, have_ask;
		int          n, s;
		book_word_t  w;
		n = 0;
		st = lobm_pkg::ST_OK;
		q = r.qty;
		bid = '0;
		ask = '0;
		spr = '0;
		have_bid = 0;
		have_ask = 0;
		if (r.func == lobm_pkg::FUNC_SUBMIT || r.func == lobm_pkg::FUNC_REST) begin
			if (q == 0)
				st = lobm_pkg::ST_ZERO_QTY;
			else begin
				while (r.func == lobm_pkg::FUNC_SUBMIT && q != 0 && n < SLOTS) begin
					s = best_maker(r.side, r.price);
					if (s < 0)
						break;
					fill = q < bk_qty[s] ? q : bk_qty[s];
					mk_id[n] = bk_id[s];
					mk_px[n] = bk_price[s];
					mk_q[n] = fill;
					n++;
					q -= fill;
					bk_qty[s] -= fill;
					if (bk_qty[s] == 0)
						bk_valid[s] = 1'b0;
				end
				if (q != 0 && !book_place(r, q))
					st = lobm_pkg::ST_FULL;
			end
		end else begin
			s = -1;
			for (int i = 0; i < SLOTS; i++)
				if (s < 0 && bk_valid[i] && bk_id[i] == r.id)
					s = i;
			if (s < 0)
				st = lobm_pkg::ST_NOT_FND;
			else if (r.func == lobm_pkg::FUNC_CANCEL || r.qty == 0)
				bk_valid[s] = 1'b0;
			else if (r.price == bk_price[s] && r.qty <= bk_qty[s])
				bk_qty[s] = r.qty;
			else begin
				bk_price[s] = r.price;
				bk_qty[s] = r.qty;
				bk_stamp[s] = arrival_ctr;
				arrival_ctr = arrival_ctr + 1;
			end
		end
		for (int k = 0; k < SLOTS; k++) begin
			if (!bk_valid[k])
				continue;
			if (bk_side[k] == 1'b0) begin
				if (!have_bid || bk_price[k] > bid)
					bid = bk_price[k];
				have_bid = 1;
			end else begin
				if (!have_ask || bk_price[k] < ask)
					ask = bk_price[k];
				have_ask = 1;
			end
		end
		if (bid != 0 && ask != 0 && ask > bid)
			spr = ask - bid;
		for (int k = 0; k < (n == 0 ? 1 : n); k++) begin
			w.trade_valid = n != 0;
			w.taker_id = n != 0 ? r.id : '0;
			w.maker_id = n != 0 ? mk_id[k] : '0;
			w.trade_price = n != 0 ? mk_px[k] : '0;
			w.trade_quantity = n != 0 ? mk_q[k] : '0;
			w.status = st;
			w.bid_top = bid;
			w.ask_top = ask;
			w.spread = spr;
			w.last = (n == 0) || (k == n - 1);
			expected_words.insert(expected_words.size(), w);
		end
	endtask

	function automatic order_req_t mk_order(logic [1:0] f, logic [31:0] id, logic sd,
			logic [31:0] px, logic [31:0] q);
		order_req_t r;
		r.func = f;
		r.id = id;
		r.side = sd;
		r.price = px;
		r.qty = q;
		r.drain = 0;
		return r;
	endfunction

	// filling mode rests non-crossing orders so the store runs full
	function automatic order_req_t rand_order(bit filling);
		order_req_t r;
		int pick;
		r.drain = 0;
		r.side = 1'($urandom_range(0, 1));
		if (filling) begin
			r.func = lobm_pkg::FUNC_REST;
			r.id = $urandom_range(1, 24);
			r.price = r.side ? 32'(1100 + $urandom_range(0, 10)) : 32'(900 + $urandom_range(0, 10));
			r.qty = $urandom_range(1, 50);
			return r;
		end
		pick = $urandom_range(0, 99);
		r.func = pick < 40 ? lobm_pkg::FUNC_SUBMIT : pick < 65 ? lobm_pkg::FUNC_REST
			: pick < 80 ? lobm_pkg::FUNC_CANCEL : lobm_pkg::FUNC_MODIFY;
		pick = $urandom_range(0, 99);
		r.id = pick < 80 ? 32'($urandom_range(1, 24)) : pick < 90 ? $urandom()
			: pick < 95 ? 32'h0 : 32'hFFFF_FFFF;
		pick = $urandom_range(0, 99);
		r.price = pick < 85 ? 32'(1000 + $urandom_range(0, 15)) : pick < 90 ? 32'h0
			: pick < 95 ? 32'hFFFF_FFFF : $urandom();
		pick = $urandom_range(0, 99);
		r.qty = pick < 80 ? 32'($urandom_range(1, 50)) : pick < 87 ? 32'h0
			: pick < 95 ? $urandom() : 32'hFFFF_FFFF;
		return r;
	endfunction

	// sample accepted words at the rising edge
	always @(posedge clk) begin
		book_word_t w;
		cycles <= cycles + 1;
		in_taken <= in_valid && !in_stall && arst_n;
		if (arst_n && in_valid && !in_stall) begin
			apply_order(mk_order(func, req_id, side, price, quantity));
			accepted <= accepted + 1;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				w = expected_words.pop_front();
				if (trade_valid !== w.trade_valid) begin
					$error("trade_valid exp %h got %h", w.trade_valid, trade_valid); errors++;
				end
				if (taker_id !== w.taker_id) begin
					$error("taker_id exp %h got %h", w.taker_id, taker_id); errors++;
				end
				if (maker_id !== w.maker_id) begin
					$error("maker_id exp %h got %h", w.maker_id, maker_id); errors++;
				end
				if (trade_price !== w.trade_price) begin
					$error("trade_price exp %h got %h", w.trade_price, trade_price); errors++;
				end
				if (trade_quantity !== w.trade_quantity) begin
					$error("trade_quantity exp %h got %h", w.trade_quantity, trade_quantity);
					errors++;
				end
				if (status !== w.status) begin
					$error("status exp %h got %h", w.status, status); errors++;
				end
				if (bid_top !== w.bid_top) begin
					$error("bid_top exp %h got %h", w.bid_top, bid_top); errors++;
				end
				if (ask_top !== w.ask_top) begin
					$error("ask_top exp %h got %h", w.ask_top, ask_top); errors++;
				end
				if (spread !== w.spread) begin
					$error("spread exp %h got %h", w.spread, spread); errors++;
				end
				if (last !== w.last) begin
					$error("last exp %h got %h", w.last, last); errors++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// sender: bursts and gaps, with an optional drain before flagged words
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		order_req_t hd;
		logic nv;
		nv = in_valid;
		if (!in_valid || in_taken) begin
			nv = 1'b0;
			if (gap_left > 0)
				gap_left--;
			else if (pending_orders.size() != 0) begin
				hd = pending_orders[0];
				if (!hd.drain || expected_words.size() == 0) begin
					void'(pending_orders.pop_front());
					func <= hd.func;
					req_id <= hd.id;
					side <= hd.side;
					price <= hd.price;
					quantity <= hd.qty;
					nv = 1'b1;
					if (burst_left > 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(0, 8);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 200);
					end
				end
			end
		end
		in_valid <= nv;
	end

	// receiver: stall pattern changes now and then, plus one long hold-off
	int pat_left = 0;
	int stall_pct = 0;
	int hold_left = 0;
	bit held = 0;
	always @(negedge clk) begin
		if (!held && accepted >= 200) begin
			held = 1;
			hold_left = HOLD_CYCLES;
		end
		if (pat_left == 0) begin
			pat_left = $urandom_range(50, 400);
			stall_pct = $urandom_range(0, 2) * 30;
		end else
			pat_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= $urandom_range(0, 99) < stall_pct;
	end

	initial begin
		order_req_t r;
		// directed
		queue_order(mk_order(lobm_pkg::FUNC_REST, 1, 0, 100, 10));
		queue_order(mk_order(lobm_pkg::FUNC_REST, 2, 1, 120, 7));
		queue_order(mk_order(lobm_pkg::FUNC_SUBMIT, 9, 0, 130, 0));
		queue_order(mk_order(lobm_pkg::FUNC_REST, 9, 1, 125, 0));
		queue_order(mk_order(lobm_pkg::FUNC_SUBMIT, 3, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		queue_order(mk_order(lobm_pkg::FUNC_CANCEL, 32'hFFFF_FFFF, 0, 0, 0));
		queue_order(mk_order(lobm_pkg::FUNC_CANCEL, 3, 1, 0, 0));
		queue_order(mk_order(lobm_pkg::FUNC_MODIFY, 77, 0, 5, 5));
		queue_order(mk_order(lobm_pkg::FUNC_REST, 4, 0, 0, 3));
		queue_order(mk_order(lobm_pkg::FUNC_REST, 5, 1, 90, 20));
		queue_order(mk_order(lobm_pkg::FUNC_MODIFY, 5, 1, 90, 15));
		queue_order(mk_order(lobm_pkg::FUNC_MODIFY, 5, 0, 90, 25));
		queue_order(mk_order(lobm_pkg::FUNC_MODIFY, 1, 1, 95, 10));
		queue_order(mk_order(lobm_pkg::FUNC_REST, 7, 0, 80, 4));
		queue_order(mk_order(lobm_pkg::FUNC_REST, 7, 0, 80, 6));
		queue_order(mk_order(lobm_pkg::FUNC_CANCEL, 7, 0, 0, 0));
		queue_order(mk_order(lobm_pkg::FUNC_REST, 8, 1, 96, 2));
		queue_order(mk_order(lobm_pkg::FUNC_SUBMIT, 8, 0, 96, 1));
		queue_order(mk_order(lobm_pkg::FUNC_MODIFY, 8, 1, 96, 0));
		queue_order(mk_order(lobm_pkg::FUNC_SUBMIT, 0, 1, 0, 40));
		queue_order(mk_order(lobm_pkg::FUNC_SUBMIT, 0, 1, 0, 32'hFFFF_FFFF));
		// random, with a run that fills the store and a sweep after it
		for (int i = 0; i < 410; i++) begin
			if (i >= 150 && i < 230)
				r = rand_order(1);
			else if (i == 230)
				r = mk_order(lobm_pkg::FUNC_SUBMIT, 50, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
			else
				r = rand_order(0);
			if (i == 100 || i == 231)
				r.drain = 1;
			queue_order(r);
		end
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (pending_orders.size() == 0);
		@(posedge clk);
		while (in_valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
